@@ hw/rtl/tss_pkg.sv @@
package tss_pkg;

  localparam int MAX_STEPS   = 32;
  localparam int REPORT_BITS = 64;
  localparam int STEP_W      = $clog2(MAX_STEPS);
  localparam int CNT_W       = 6;
  localparam int LIM_W       = $clog2(MAX_STEPS + 3);
  localparam int TIME_W      = 32;
  localparam int ADDR_W      = 5;
  localparam int DATA_W      = 64;

  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;
  localparam logic [1:0] KIND_LOAD  = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_STEPS = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;

  localparam logic [1:0] REG_STEP_COUNT = 2'd0;
  localparam logic [1:0] REG_LOOP_GAP   = 2'd1;
  localparam logic [1:0] REG_REPEAT     = 2'd2;
  localparam logic [1:0] REG_NEUTRAL    = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0]       step_count;
    logic [TIME_W-1:0]      loop_gap_ms;
    logic                   repeat_on;
    logic [REPORT_BITS-1:0] neutral_report;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic load_wr;
    logic stop;
    logic start_init;
    logic start_go;
    logic read_pos;
    logic add_len;
    logic advance;
    logic adv_apply;
    logic resync;
    logic clr_changed;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       running;
    logic       eff_zero;
    logic       expired;
    logic       adv_rd;
    logic       limit_hit;
  } stat_t;

endpackage

@@ hw/rtl/tss_cfg.sv @@
module tss_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]  paddr,
  input  logic [tss_pkg::DATA_W-1:0]  pwdata,
  output logic [tss_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output tss_pkg::cfg_t               cfg
);
  import tss_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_sel;

  assign reg_sel = paddr[4:3];
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_STEP_COUNT: cfg_nxt.step_count     = pwdata[CNT_W-1:0];
        REG_LOOP_GAP:   cfg_nxt.loop_gap_ms    = pwdata[TIME_W-1:0];
        REG_REPEAT:     cfg_nxt.repeat_on      = pwdata[0];
        REG_NEUTRAL:    cfg_nxt.neutral_report = pwdata[REPORT_BITS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_STEP_COUNT: prdata = DATA_W'(cfg_r.step_count);
      REG_LOOP_GAP:   prdata = DATA_W'(cfg_r.loop_gap_ms);
      REG_REPEAT:     prdata = DATA_W'(cfg_r.repeat_on);
      REG_NEUTRAL:    prdata = DATA_W'(cfg_r.neutral_report);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/tss_ctrl.sv @@
module tss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  input  tss_pkg::stat_t stat,
  output tss_pkg::cmd_t  cmd
);
  import tss_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_START_WR = 3'd2;
  localparam logic [2:0] S_CMP      = 3'd3;
  localparam logic [2:0] S_ADV      = 3'd4;
  localparam logic [2:0] S_ADV_WR   = 3'd5;
  localparam logic [2:0] S_RESULT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESULT);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.kind)
          KIND_TICK: begin
            cmd.read_pos = stat.running;
            state_nxt    = stat.running ? S_CMP : S_RESULT;
          end
          KIND_START: begin
            cmd.start_init = 1'b1;
            state_nxt      = stat.eff_zero ? S_RESULT : S_START_WR;
          end
          KIND_STOP: begin
            cmd.stop  = 1'b1;
            state_nxt = S_RESULT;
          end
          default: begin
            cmd.load_wr = 1'b1;
            state_nxt   = S_RESULT;
          end
        endcase
      end
      S_START_WR: begin
        cmd.start_go = 1'b1;
        state_nxt    = S_RESULT;
      end
      S_CMP: begin
        if (stat.running && stat.expired) begin
          cmd.add_len = 1'b1;
          state_nxt   = S_ADV;
        end else begin
          state_nxt = S_RESULT;
        end
      end
      S_ADV: begin
        cmd.advance = 1'b1;
        if (stat.adv_rd) begin
          state_nxt = S_ADV_WR;
        end else if (stat.limit_hit) begin
          cmd.resync = 1'b1;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_ADV_WR: begin
        cmd.adv_apply = 1'b1;
        if (stat.limit_hit) begin
          cmd.resync = 1'b1;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_RESULT: begin
        cmd.clr_changed = 1'b1;
        state_nxt       = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/tss_dp.sv @@
module tss_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [1:0]                      in_kind,
  input  logic [tss_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [4:0]                      in_entry_index,
  input  logic [tss_pkg::TIME_W-1:0]      in_entry_duration,
  input  logic [63:0]                     in_entry_report,
  input  tss_pkg::cfg_t                   cfg,
  input  tss_pkg::cmd_t                   cmd,
  output tss_pkg::stat_t                  stat,
  output logic [63:0]                     out_report,
  output logic                            out_report_changed,
  output logic                            out_is_running,
  output logic [1:0]                      out_phase,
  output logic [4:0]                      out_current_step,
  output logic [tss_pkg::TIME_W-1:0]      out_passes_done
);
  import tss_pkg::*;

  // step table, no reset
  logic [TIME_W-1:0]      mem_dur [MAX_STEPS];
  logic [REPORT_BITS-1:0] mem_rpt [MAX_STEPS];
  logic [TIME_W-1:0]      rd_dur_r;
  logic [REPORT_BITS-1:0] rd_rpt_r;
  logic                   rd_en;
  logic [STEP_W-1:0]      rd_addr;

  // latched transaction
  logic [1:0]             kind_r, kind_nxt;
  logic [TIME_W-1:0]      now_r, now_nxt;
  logic [4:0]             idx_r, idx_nxt;
  logic [TIME_W-1:0]      dur_in_r, dur_in_nxt;
  logic [REPORT_BITS-1:0] rpt_in_r, rpt_in_nxt;

  logic                   running_r, running_nxt;
  logic [1:0]             phase_r, phase_nxt;
  logic [STEP_W-1:0]      pos_r, pos_nxt;
  logic [TIME_W-1:0]      start_r, start_nxt;
  logic [TIME_W-1:0]      pass_r, pass_nxt;
  logic [REPORT_BITS-1:0] cur_rpt_r, cur_rpt_nxt;
  logic                   changed_r, changed_nxt;
  logic [LIM_W-1:0]       done_r, done_nxt;

  logic [CNT_W-1:0]       eff;
  logic [LIM_W-1:0]       limit;
  logic [TIME_W-1:0]      len;
  logic [TIME_W-1:0]      elapsed;
  logic [CNT_W-1:0]       pos_inc;
  logic                   adv_rd;
  logic [STEP_W-1:0]      adv_addr;
  logic                   put_en;
  logic [REPORT_BITS-1:0] put_val;
  logic                   force_chg;

  assign eff     = (cfg.step_count > CNT_W'(MAX_STEPS)) ? CNT_W'(MAX_STEPS) : cfg.step_count;
  assign limit   = LIM_W'(eff) + LIM_W'(2);
  assign elapsed = now_r - start_r;
  assign pos_inc = CNT_W'(pos_r) + CNT_W'(1);

  always_comb begin
    case (phase_r)
      PH_STEPS: len = rd_dur_r;
      PH_GAP:   len = cfg.loop_gap_ms;
      default:  len = TIME_W'(1);
    endcase
  end

  // where the next advance goes and whether it needs a table entry
  always_comb begin
    adv_rd   = 1'b0;
    adv_addr = '0;
    if (phase_r == PH_GAP) begin
      adv_rd = 1'b1;
    end else if (pos_inc < eff) begin
      adv_rd   = 1'b1;
      adv_addr = pos_inc[STEP_W-1:0];
    end else if (cfg.repeat_on && (cfg.loop_gap_ms == '0)) begin
      adv_rd = 1'b1;
    end
  end

  always_comb begin
    kind_nxt    = kind_r;
    now_nxt     = now_r;
    idx_nxt     = idx_r;
    dur_in_nxt  = dur_in_r;
    rpt_in_nxt  = rpt_in_r;
    running_nxt = running_r;
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    start_nxt   = start_r;
    pass_nxt    = pass_r;
    cur_rpt_nxt = cur_rpt_r;
    changed_nxt = changed_r;
    done_nxt    = done_r;
    put_en      = 1'b0;
    put_val     = cfg.neutral_report;
    force_chg   = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = '0;

    if (cmd.latch) begin
      kind_nxt   = in_kind;
      now_nxt    = in_now_ms;
      idx_nxt    = in_entry_index;
      dur_in_nxt = in_entry_duration;
      rpt_in_nxt = in_entry_report[REPORT_BITS-1:0];
    end
    if (cmd.start_init) begin
      pass_nxt  = '0;
      pos_nxt   = '0;
      start_nxt = now_r;
      rd_en     = 1'b1;
      if (eff == '0) begin
        running_nxt = 1'b0;
        phase_nxt   = PH_IDLE;
        put_en      = 1'b1;
      end
    end
    if (cmd.start_go) begin
      running_nxt = 1'b1;
      phase_nxt   = PH_STEPS;
      put_en      = 1'b1;
      put_val     = rd_rpt_r;
      force_chg   = 1'b1;
    end
    if (cmd.stop) begin
      running_nxt = 1'b0;
      phase_nxt   = PH_IDLE;
      pos_nxt     = '0;
      put_en      = 1'b1;
      force_chg   = 1'b1;
    end
    if (cmd.read_pos) begin
      rd_en    = 1'b1;
      rd_addr  = pos_r;
      done_nxt = '0;
    end
    if (cmd.add_len) begin
      start_nxt = start_r + len;
      done_nxt  = done_r + LIM_W'(1);
    end
    if (cmd.advance) begin
      rd_en   = adv_rd;
      rd_addr = adv_addr;
      if (phase_r == PH_GAP) begin
        phase_nxt = PH_STEPS;
        pos_nxt   = '0;
      end else if (pos_inc < eff) begin
        pos_nxt = pos_inc[STEP_W-1:0];
      end else begin
        // end of pass
        pass_nxt = pass_r + TIME_W'(1);
        pos_nxt  = '0;
        if (!cfg.repeat_on) begin
          running_nxt = 1'b0;
          phase_nxt   = PH_IDLE;
          put_en      = 1'b1;
        end else if (cfg.loop_gap_ms != '0) begin
          phase_nxt = PH_GAP;
          put_en    = 1'b1;
        end else begin
          phase_nxt = PH_STEPS;
        end
      end
    end
    if (cmd.adv_apply) begin
      put_en  = 1'b1;
      put_val = rd_rpt_r;
    end
    if (cmd.resync) begin
      start_nxt = now_r;
    end
    if (put_en && (put_val != cur_rpt_r)) begin
      cur_rpt_nxt = put_val;
      changed_nxt = 1'b1;
    end
    if (force_chg) begin
      changed_nxt = 1'b1;
    end
    if (cmd.clr_changed) begin
      changed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && (32'(idx_r) < MAX_STEPS)) begin
      mem_dur[STEP_W'(idx_r)] <= dur_in_r;
      mem_rpt[STEP_W'(idx_r)] <= rpt_in_r;
    end
    if (rd_en) begin
      rd_dur_r <= mem_dur[rd_addr];
      rd_rpt_r <= mem_rpt[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    now_r    <= now_nxt;
    idx_r    <= idx_nxt;
    dur_in_r <= dur_in_nxt;
    rpt_in_r <= rpt_in_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      phase_r   <= PH_IDLE;
      pos_r     <= '0;
      start_r   <= '0;
      pass_r    <= '0;
      cur_rpt_r <= '0;
      changed_r <= 1'b0;
      done_r    <= '0;
    end else begin
      running_r <= running_nxt;
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      start_r   <= start_nxt;
      pass_r    <= pass_nxt;
      cur_rpt_r <= cur_rpt_nxt;
      changed_r <= changed_nxt;
      done_r    <= done_nxt;
    end
  end

  assign stat.kind      = kind_r;
  assign stat.running   = running_r;
  assign stat.eff_zero  = (eff == '0);
  assign stat.expired   = (elapsed >= len);
  assign stat.adv_rd    = adv_rd;
  assign stat.limit_hit = (done_r >= limit);

  assign out_report         = 64'(cur_rpt_r);
  assign out_report_changed = changed_r;
  assign out_is_running     = running_r;
  assign out_phase          = phase_r;
  assign out_current_step   = 5'(pos_r);
  assign out_passes_done    = pass_r;

endmodule

@@ hw/rtl/timed_step_sequencer.sv @@
// Each transaction goes from decode to result: load, stop and a start with no steps go there
// directly, a start with steps through a start-write state; a running tick compares and advances,
// with a write state after each advance that reads the step table, until the step or gap has not
// expired or the walk stops at the limit of step_count + 2 advances (step_count capped at 32).
// One transaction at a time; out_valid strobes for one cycle, busy drops the cycle after.
// Synchronous active-low reset clears control and config; the step table is not cleared.
module timed_step_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_kind,
  input  logic [tss_pkg::TIME_W-1:0]      in_now_ms,
  input  logic [4:0]                      in_entry_index,
  input  logic [tss_pkg::TIME_W-1:0]      in_entry_duration,
  input  logic [63:0]                     in_entry_report,
  output logic                            out_valid,
  output logic [63:0]                     out_report,
  output logic                            out_report_changed,
  output logic                            out_is_running,
  output logic [1:0]                      out_phase,
  output logic [4:0]                      out_current_step,
  output logic [tss_pkg::TIME_W-1:0]      out_passes_done,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tss_pkg::ADDR_W-1:0]      paddr,
  input  logic [tss_pkg::DATA_W-1:0]      pwdata,
  output logic [tss_pkg::DATA_W-1:0]      prdata,
  output logic                            pready
);
  import tss_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tss_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  tss_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_now_ms          (in_now_ms),
    .in_entry_index     (in_entry_index),
    .in_entry_duration  (in_entry_duration),
    .in_entry_report    (in_entry_report),
    .cfg                (cfg),
    .cmd                (cmd),
    .stat               (stat),
    .out_report         (out_report),
    .out_report_changed (out_report_changed),
    .out_is_running     (out_is_running),
    .out_phase          (out_phase),
    .out_current_step   (out_current_step),
    .out_passes_done    (out_passes_done)
  );

endmodule

@@ hw/rtl/tss_checker.sv @@
module tss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_is_running,
  input logic [1:0] out_phase
);
  import tss_pkg::*;

  // each accepted transaction keeps the block busy until its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // a result is only shown while busy, and frees the block right after
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 (!busy && !out_valid))
    else $error("result strobe not followed by idle");

  // running and phase agree on every result
  a_run_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_running == (out_phase != PH_IDLE)))
    else $error("running flag and phase disagree");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid && !out_is_running))
    else $error("block not idle after reset");

endmodule

bind timed_step_sequencer tss_checker u_tss_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_is_running (out_is_running),
  .out_phase      (out_phase)
);
